/* rtl/core/mrac_pkg.sv */
// ----------------------------------------------------------------------------
// mrac_pkg
// Shared types and constants for the retransmit / acknowledgement controller.
// ----------------------------------------------------------------------------
package mrac_pkg;

    localparam int TIMER_W        = 20;
    localparam int MAX_COLLISIONS = 4;
    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
    localparam logic [7:0] DEFAULT_ATTEMPTS = 8'd5;
    localparam logic [2:0] ACK_TYPE = 3'd2;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_RESULT  = 2'd1,
        OP_RXFRAME = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_DONE    = 2'd1,
        ACT_VERDICT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOACK     = 2'd1,
        ST_COLLISION = 2'd2,
        ST_ERROR     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RADIO_OK        = 2'd0,
        RADIO_COLLISION = 2'd1,
        RADIO_ERROR     = 2'd2,
        RADIO_OTHER     = 2'd3
    } radio_t;

    typedef enum logic [2:0] {
        REG_ACK_DETECT   = 3'd0,
        REG_ACK_RECEIVE  = 3'd1,
        REG_COLL_BASE    = 3'd2,
        REG_RETRY_GAP    = 3'd3,
        REG_AUTO_ACK     = 3'd4,
        REG_MIN_LEN      = 3'd5,
        REG_SPARE6       = 3'd6,
        REG_SPARE7       = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [15:0] ack_detect_ticks;
        logic [15:0] ack_receive_ticks;
        logic [15:0] collision_base_ticks;
        logic [15:0] retry_gap_ticks;
        logic        auto_ack_enable;
        logic [6:0]  min_frame_length;
    } cfg_t;

    typedef struct packed {
        logic       channel_busy;
        logic [7:0] frame_sequence;
        logic [7:0] frame_control_byte;
        logic [6:0] frame_length;
        logic [1:0] radio_result;
        logic [7:0] attempt_limit;
        logic       broadcast;
        logic [7:0] sequence_number;
        logic [1:0] operation;
    } item_t;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] status;
        logic       keep_frame;
        logic [7:0] transmissions;
    } result_t;

endpackage

/* rtl/core/mrac_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mrac_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module mrac_cfg_regs (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output mrac_pkg::cfg_t   cfg
);

    mrac_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_detect_ticks     <= 16'd100;
            cfg_reg.ack_receive_ticks    <= 16'd200;
            cfg_reg.collision_base_ticks <= 16'd50;
            cfg_reg.retry_gap_ticks      <= 16'd20;
            cfg_reg.auto_ack_enable      <= 1'b1;
            cfg_reg.min_frame_length     <= 7'd3;
        end else if (cfg_valid) begin
            unique case (mrac_pkg::reg_index_t'(cfg_index))
                mrac_pkg::REG_ACK_DETECT:  cfg_reg.ack_detect_ticks     <= cfg_data;
                mrac_pkg::REG_ACK_RECEIVE: cfg_reg.ack_receive_ticks    <= cfg_data;
                mrac_pkg::REG_COLL_BASE:   cfg_reg.collision_base_ticks <= cfg_data;
                mrac_pkg::REG_RETRY_GAP:   cfg_reg.retry_gap_ticks      <= cfg_data;
                mrac_pkg::REG_AUTO_ACK:    cfg_reg.auto_ack_enable      <= cfg_data[0];
                mrac_pkg::REG_MIN_LEN:     cfg_reg.min_frame_length     <= cfg_data[6:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

endmodule

/* rtl/core/mrac_engine.sv */
// ----------------------------------------------------------------------------
// mrac_engine
// Transmit state machine: applies one item per enabled cycle to the frame
// state and produces at most one result.
// ----------------------------------------------------------------------------
module mrac_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  mrac_pkg::item_t     item,
    input  mrac_pkg::cfg_t      cfg,
    output logic                res_valid,
    output mrac_pkg::result_t   res
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SENDING = 3'd1,
        PH_DETECT  = 3'd2,
        PH_RECEIVE = 3'd3,
        PH_BACKOFF = 3'd4,
        PH_GAP     = 3'd5
    } phase_t;

    localparam int TW = mrac_pkg::TIMER_W;

    phase_t        phase_reg, phase_next;
    logic [TW-1:0] timer_reg, timer_next;
    logic [7:0]    attempt_reg, attempt_next;
    logic [2:0]    coll_reg, coll_next;
    logic [7:0]    attempt_max_reg, attempt_max_next;
    logic [7:0]    seq_reg, seq_next;
    logic [7:0]    sends_reg, sends_next;
    logic          ack_seen_reg, ack_seen_next;
    logic          bcast_reg, bcast_next;
    logic [1:0]    last_status_reg, last_status_next;

    logic [22:0]   backoff_raw;
    logic [TW-1:0] backoff;
    logic [2:0]    coll_inc;
    logic [TW-1:0] timer_dec;
    logic [7:0]    sends_inc;
    logic [7:0]    attempt_inc;

    assign backoff_raw = {7'd0, cfg.collision_base_ticks} << coll_reg;
    assign backoff     = (backoff_raw > {3'd0, mrac_pkg::TIMER_MAX}) ?
                         mrac_pkg::TIMER_MAX : backoff_raw[TW-1:0];
    assign coll_inc    = coll_reg + 3'd1;
    assign timer_dec   = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
    assign sends_inc   = sends_reg + 8'd1;
    assign attempt_inc = attempt_reg + 8'd1;

    always_comb begin
        phase_next       = phase_reg;
        timer_next       = timer_reg;
        attempt_next     = attempt_reg;
        coll_next        = coll_reg;
        attempt_max_next = attempt_max_reg;
        seq_next         = seq_reg;
        sends_next       = sends_reg;
        ack_seen_next    = ack_seen_reg;
        bcast_next       = bcast_reg;
        last_status_next = last_status_reg;
        res_valid        = 1'b0;
        res.action       = mrac_pkg::ACT_SEND;
        res.status       = mrac_pkg::ST_OK;
        res.keep_frame   = 1'b0;
        res.transmissions = sends_reg;

        unique case (mrac_pkg::op_t'(item.operation))
            mrac_pkg::OP_START: begin
                seq_next         = item.sequence_number;
                bcast_next       = item.broadcast;
                attempt_max_next = (item.attempt_limit != 8'd0) ?
                                   item.attempt_limit : mrac_pkg::DEFAULT_ATTEMPTS;
                attempt_next     = 8'd0;
                coll_next        = 3'd0;
                sends_next       = 8'd0;
                ack_seen_next    = 1'b0;
                last_status_next = mrac_pkg::ST_ERROR;
                timer_next       = '0;
                phase_next       = PH_SENDING;
                res_valid        = 1'b1;
                res.action       = mrac_pkg::ACT_SEND;
                res.transmissions = 8'd0;
            end
            mrac_pkg::OP_RESULT: begin
                if (phase_reg == PH_SENDING) begin
                    unique case (mrac_pkg::radio_t'(item.radio_result))
                        mrac_pkg::RADIO_OK: begin
                            sends_next   = sends_inc;
                            attempt_next = attempt_inc;
                            if (bcast_reg) begin
                                phase_next        = PH_IDLE;
                                timer_next        = '0;
                                last_status_next  = mrac_pkg::ST_OK;
                                res_valid         = 1'b1;
                                res.action        = mrac_pkg::ACT_DONE;
                                res.status        = mrac_pkg::ST_OK;
                                res.transmissions = sends_inc;
                            end else begin
                                last_status_next = mrac_pkg::ST_NOACK;
                                phase_next       = PH_DETECT;
                                timer_next       = {4'd0, cfg.ack_detect_ticks};
                            end
                        end
                        mrac_pkg::RADIO_COLLISION: begin
                            timer_next = backoff;
                            phase_next = PH_BACKOFF;
                            // a run of collisions past the limit costs one attempt
                            if (coll_inc > 3'(mrac_pkg::MAX_COLLISIONS)) begin
                                coll_next    = 3'd0;
                                attempt_next = attempt_inc;
                            end else begin
                                coll_next = coll_inc;
                            end
                            last_status_next = mrac_pkg::ST_COLLISION;
                        end
                        default: begin
                            phase_next       = PH_IDLE;
                            timer_next       = '0;
                            last_status_next = mrac_pkg::ST_ERROR;
                            res_valid        = 1'b1;
                            res.action       = mrac_pkg::ACT_DONE;
                            res.status       = mrac_pkg::ST_ERROR;
                        end
                    endcase
                end
            end
            mrac_pkg::OP_RXFRAME: begin
                if (item.frame_length >= cfg.min_frame_length) begin
                    res_valid         = 1'b1;
                    res.action        = mrac_pkg::ACT_VERDICT;
                    res.keep_frame    = 1'b1;
                    res.transmissions = 8'd0;
                    if (item.frame_control_byte[2:0] == mrac_pkg::ACK_TYPE) begin
                        if (item.frame_sequence == seq_reg && sends_reg != 8'd0) begin
                            ack_seen_next = 1'b1;
                        end
                        if (cfg.auto_ack_enable) begin
                            res.keep_frame = 1'b0;
                        end
                    end
                end
            end
            default: begin
                // tick: only the waiting phases react
                priority if (phase_reg == PH_IDLE || phase_reg == PH_SENDING) begin
                end else if ((phase_reg == PH_DETECT || phase_reg == PH_RECEIVE)
                             && ack_seen_reg) begin
                    phase_next       = PH_IDLE;
                    timer_next       = '0;
                    last_status_next = mrac_pkg::ST_OK;
                    res_valid        = 1'b1;
                    res.action       = mrac_pkg::ACT_DONE;
                    res.status       = mrac_pkg::ST_OK;
                end else begin
                    timer_next = timer_dec;
                    if (timer_dec == '0) begin
                        unique case (phase_reg)
                            PH_DETECT: begin
                                if (item.channel_busy) begin
                                    phase_next = PH_RECEIVE;
                                    timer_next = {4'd0, cfg.ack_receive_ticks};
                                end else begin
                                    last_status_next = mrac_pkg::ST_NOACK;
                                    phase_next       = PH_GAP;
                                    timer_next       = {4'd0, cfg.retry_gap_ticks};
                                end
                            end
                            PH_RECEIVE: begin
                                last_status_next = mrac_pkg::ST_NOACK;
                                phase_next       = PH_GAP;
                                timer_next       = {4'd0, cfg.retry_gap_ticks};
                            end
                            PH_BACKOFF: begin
                                phase_next = PH_GAP;
                                timer_next = {4'd0, cfg.retry_gap_ticks};
                            end
                            default: begin
                                res_valid = 1'b1;
                                if (attempt_reg < attempt_max_reg) begin
                                    phase_next = PH_SENDING;
                                    res.action = mrac_pkg::ACT_SEND;
                                end else begin
                                    phase_next = PH_IDLE;
                                    timer_next = '0;
                                    res.action = mrac_pkg::ACT_DONE;
                                    res.status = last_status_reg;
                                end
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            timer_reg       <= '0;
            attempt_reg     <= 8'd0;
            coll_reg        <= 3'd0;
            attempt_max_reg <= mrac_pkg::DEFAULT_ATTEMPTS;
            seq_reg         <= 8'd0;
            sends_reg       <= 8'd0;
            ack_seen_reg    <= 1'b0;
            bcast_reg       <= 1'b0;
            last_status_reg <= mrac_pkg::ST_ERROR;
        end else if (en) begin
            phase_reg       <= phase_next;
            timer_reg       <= timer_next;
            attempt_reg     <= attempt_next;
            coll_reg        <= coll_next;
            attempt_max_reg <= attempt_max_next;
            seq_reg         <= seq_next;
            sends_reg       <= sends_next;
            ack_seen_reg    <= ack_seen_next;
            bcast_reg       <= bcast_next;
            last_status_reg <= last_status_next;
        end
    end

endmodule

/* rtl/core/mac_retransmit_ack_controller_top.sv */
// ----------------------------------------------------------------------------
// mac_retransmit_ack_controller_top
// Acknowledged-retransmission transmit controller with stream ports.
// ----------------------------------------------------------------------------
// One item is taken per clock unless the input register is held. An accepted
// item sits in the input register until it is applied to the frame state by
// the state update; its result (if any) is written into the result register
// by the same update and appears from there. The input register moves on
// whenever the result register is empty or being emptied, so input and output
// stall only on a full result register. Configuration writes are accepted
// every cycle and must be made while no item is in flight.
// ----------------------------------------------------------------------------
module mac_retransmit_ack_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] sequence_number, [8] broadcast, [16:9] attempt_limit,
    // [18:17] radio_result, [25:19] frame_length, [33:26] frame_control_byte,
    // [41:34] frame_sequence, [42] channel_busy, [47:43] zero
    input  logic [47:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [2] keep_frame, [10:3] transmissions, [15:11] zero
    output logic [15:0] m_tdata,
    // [1:0] action
    output logic [1:0]  m_tuser,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    mrac_pkg::cfg_t    cfg;
    mrac_pkg::item_t   item_reg;
    logic              in_valid_reg;
    logic              out_free;
    logic              proc;
    logic              res_valid;
    mrac_pkg::result_t res;
    mrac_pkg::result_t out_reg;
    logic              out_valid_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || proc;

    mrac_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mrac_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (proc),
        .item      (item_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.operation          <= s_tuser;
            item_reg.sequence_number    <= s_tdata[7:0];
            item_reg.broadcast          <= s_tdata[8];
            item_reg.attempt_limit      <= s_tdata[16:9];
            item_reg.radio_result       <= s_tdata[18:17];
            item_reg.frame_length       <= s_tdata[25:19];
            item_reg.frame_control_byte <= s_tdata[33:26];
            item_reg.frame_sequence     <= s_tdata[41:34];
            item_reg.channel_busy       <= s_tdata[42];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= proc && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.action;
    assign m_tdata  = {5'd0, out_reg.transmissions, out_reg.keep_frame, out_reg.status};

    // a held item stays put until it is applied
    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc) |=> (in_valid_reg && $stable(item_reg)))
        else $error("input register lost or changed a pending item");

    // input side never stalls while the result register can take a result
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_free |-> s_tready)
        else $error("input stalled with free result register");

    // a verdict carries no transmission count or status
    a_verdict_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && res_valid && res.action == mrac_pkg::ACT_VERDICT)
        |=> (m_tdata[10:3] == 8'd0 && m_tdata[1:0] == 2'd0))
        else $error("verdict result with stray fields");

endmodule
